@@ rtl/core/bc3_pkg.sv @@
package bc3_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int COEF_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [2:0] CFG_WIDTH_PIXELS  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT_ROWS   = 3'd1;
  localparam logic [2:0] CFG_KERNEL_LEFT   = 3'd2;
  localparam logic [2:0] CFG_KERNEL_CENTER = 3'd3;
  localparam logic [2:0] CFG_KERNEL_RIGHT  = 3'd4;
  localparam logic [2:0] CFG_DIVISOR       = 3'd5;

  localparam logic [11:0] WIDTH_RESET   = 12'd640;
  localparam logic [15:0] HEIGHT_RESET  = 16'd480;
  localparam logic [47:0] KLEFT_RESET   = 48'h0;
  localparam logic [47:0] KCENTER_RESET = 48'h0001_0000_0000;
  localparam logic [47:0] KRIGHT_RESET  = 48'h0;
  localparam logic [15:0] DIVISOR_RESET = 16'd1;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic [15:0] out_row;
    logic [10:0] out_column;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       shift;
    logic       mac_clr;
    logic       mac_en;
    logic [1:0] tap_row;
    logic [1:0] tap_col;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } cmd_t;

endpackage

@@ rtl/core/bc3_ctrl.sv @@
module bc3_ctrl #(
  parameter int MAX_WIDTH = bc3_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS = bc3_pkg::COEF_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_WIDTH),
  localparam int EW = (CNT_W + 1 > 12) ? CNT_W + 1 : 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic [11:0]         width_pixels,
  input  logic [15:0]         height_rows,
  output bc3_pkg::cmd_t       cmd,
  output logic [CNT_W-1:0]    pos_col,
  output logic [15:0]         pos_row
);

  localparam int DIV_N = COEF_BITS + 11;
  localparam int DC_W  = $clog2(DIV_N);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DINIT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [15:0]      row_cnt_r, row_cnt_nxt;
  logic             interior_r, interior_nxt;
  logic [1:0]       tap_row_r, tap_row_nxt, tap_col_r, tap_col_nxt;
  logic [DC_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [EW-1:0]    w_lo, w_eff;
  logic [15:0]      h_eff;
  logic             wrap_col;
  logic [16:0]      row_tmp, row_inc;
  logic [CNT_W-1:0] col_cur;
  logic [15:0]      row_cur;
  logic [EW-1:0]    col_inc;

  // Effective frame size and the position of the arriving word.
  always_comb begin
    w_lo     = (width_pixels < 12'd3) ? EW'(3) : EW'(width_pixels);
    w_eff    = (w_lo > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_lo;
    h_eff    = (height_rows < 16'd3) ? 16'd3 : height_rows;
    wrap_col = EW'(col_cnt_r) >= w_eff;
    col_cur  = wrap_col ? '0 : col_cnt_r;
    row_tmp  = wrap_col ? 17'(row_cnt_r) + 17'd1 : 17'(row_cnt_r);
    row_cur  = (row_tmp >= 17'(h_eff)) ? 16'd0 : row_tmp[15:0];
    col_inc  = EW'(col_cur) + EW'(1);
    row_inc  = 17'(row_cur) + 17'd1;
  end

  assign pos_col   = col_cur;
  assign pos_row   = row_cur;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    col_cnt_nxt  = col_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    interior_nxt = interior_r;
    tap_row_nxt  = tap_row_r;
    tap_col_nxt  = tap_col_r;
    div_cnt_nxt  = div_cnt_r;
    cmd          = '0;
    cmd.tap_row  = tap_row_r;
    cmd.tap_col  = tap_col_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          interior_nxt = (row_cur >= 16'd2) && (col_cur >= CNT_W'(2));
          if (col_inc >= w_eff) begin
            col_cnt_nxt = '0;
            row_cnt_nxt = (row_inc >= 17'(h_eff)) ? 16'd0 : row_inc[15:0];
          end else begin
            col_cnt_nxt = col_inc[CNT_W-1:0];
            row_cnt_nxt = row_cur;
          end
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.shift   = 1'b1;
        cmd.mac_clr = 1'b1;
        tap_row_nxt = 2'd0;
        tap_col_nxt = 2'd0;
        state_nxt   = interior_r ? S_MAC : S_IDLE;
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        if (tap_col_r == 2'd2) begin
          tap_col_nxt = 2'd0;
          tap_row_nxt = tap_row_r + 2'd1;
          if (tap_row_r == 2'd2) begin
            state_nxt = S_DINIT;
          end
        end else begin
          tap_col_nxt = tap_col_r + 2'd1;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + DC_W'(1);
        if (div_cnt_r == DC_W'(DIV_N - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      interior_r  <= 1'b0;
      tap_row_r   <= 2'd0;
      tap_col_r   <= 2'd0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      interior_r  <= interior_nxt;
      tap_row_r   <= tap_row_nxt;
      tap_col_r   <= tap_col_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_to_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_WRITE)
    else $error("accepted word did not move to line store update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_ready)
    else $error("pending result overwritten");

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC |-> tap_row_r != 2'd3 && tap_col_r != 2'd3)
    else $error("window tap out of range");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside of the done state");

endmodule

@@ rtl/core/bc3_datapath.sv @@
module bc3_datapath #(
  parameter int MAX_WIDTH = bc3_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS = bc3_pkg::COEF_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_WIDTH)
) (
  input  logic               clk,
  input  bc3_pkg::cmd_t      cmd,
  input  bc3_pkg::in_word_t  in_px,
  input  logic [CNT_W-1:0]   pos_col,
  input  logic [15:0]        pos_row,
  input  logic [47:0]        kernel_left,
  input  logic [47:0]        kernel_center,
  input  logic [47:0]        kernel_right,
  input  logic [15:0]        divisor,
  output bc3_pkg::out_word_t out_word
);

  localparam int ACC_W = COEF_BITS + 12;
  localparam int DIV_N = ACC_W - 1;
  localparam int PR_W  = COEF_BITS + 9;

  logic [23:0] upper_mem [MAX_WIDTH];
  logic [23:0] lower_mem [MAX_WIDTH];
  logic [23:0] top_q_r, mid_q_r, px_r;
  logic [CNT_W-1:0] addr_r;
  logic [15:0] row_r;
  logic [23:0] win_r [3][3];

  logic signed [ACC_W-1:0] acc_r [3];
  logic [DIV_N-1:0] quo_r [3];
  logic [16:0]      rem_r [3];
  logic [16:0]      dmag_r;
  logic             neg_r;
  bc3_pkg::out_word_t out_r;

  logic [47:0]             kcol;
  logic signed [COEF_BITS-1:0] weight;
  logic [23:0]             tap_px;
  logic signed [PR_W-1:0]  prod [3];
  logic [16:0]             dmag;
  logic [16:0]             rem_sh [3];
  logic [7:0]              res [3];

  // Line stores: read at the arriving column, then rotated one row down.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      top_q_r <= upper_mem[pos_col];
      mid_q_r <= lower_mem[pos_col];
    end
    if (cmd.shift) begin
      upper_mem[addr_r] <= mid_q_r;
      lower_mem[addr_r] <= px_r;
    end
  end

  always_comb begin
    case (cmd.tap_col)
      2'd0:    kcol = kernel_left;
      2'd1:    kcol = kernel_center;
      default: kcol = kernel_right;
    endcase
    weight = $signed(kcol[16*cmd.tap_row +: COEF_BITS]);
    tap_px = win_r[cmd.tap_row][cmd.tap_col];
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = $signed({1'b0, tap_px[8*ch +: 8]}) * weight;
    end
    if (divisor == 16'd0) begin
      dmag = 17'd1;
    end else if (divisor[15]) begin
      dmag = 17'd0 - {divisor[15], divisor};
    end else begin
      dmag = {1'b0, divisor};
    end
    for (int ch = 0; ch < 3; ch++) begin
      rem_sh[ch] = {rem_r[ch][15:0], quo_r[ch][DIV_N-1]};
      res[ch] = neg_r ? 8'(8'd0 - quo_r[ch][7:0]) : quo_r[ch][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r   <= {in_px.red, in_px.green, in_px.blue};
      addr_r <= pos_col;
      row_r  <= pos_row;
    end
    if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= top_q_r;
      win_r[1][2] <= mid_q_r;
      win_r[2][2] <= px_r;
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.mac_clr) begin
        acc_r[ch] <= '0;
      end else if (cmd.mac_en) begin
        acc_r[ch] <= acc_r[ch] + ACC_W'(prod[ch]);
      end
      if (cmd.div_init) begin
        quo_r[ch] <= acc_r[ch][ACC_W-1] ? '0 : acc_r[ch][DIV_N-1:0];
        rem_r[ch] <= '0;
      end else if (cmd.div_step) begin
        if (rem_sh[ch] >= dmag_r) begin
          rem_r[ch] <= rem_sh[ch] - dmag_r;
          quo_r[ch] <= {quo_r[ch][DIV_N-2:0], 1'b1};
        end else begin
          rem_r[ch] <= rem_sh[ch];
          quo_r[ch] <= {quo_r[ch][DIV_N-2:0], 1'b0};
        end
      end
    end
    if (cmd.div_init) begin
      dmag_r <= dmag;
      neg_r  <= divisor[15];
    end
    if (cmd.out_load) begin
      out_r.out_blue   <= res[0];
      out_r.out_green  <= res[1];
      out_r.out_red    <= res[2];
      out_r.out_row    <= row_r - 16'd1;
      out_r.out_column <= 11'(16'(addr_r) - 16'd1);
    end
  end

  assign out_word = out_r;

endmodule

@@ rtl/core/bgra_convolution_3x3_unit.sv @@
// Streaming 3x3 convolution over the blue, green and red bytes of a pixel
// stream in raster order. Each accepted word is one pixel; when the pixel at
// row r, column c arrives with r and c both at least 2, the unit returns the
// filtered pixel (r-1, c-1) with its position, so border pixels give no
// result. Per channel the signed weighted sum of the neighborhood is clamped
// at zero, divided by the divisor register (zero acts as one, truncating
// toward zero) and wrapped to 8 bits. After the line store update, an
// interior pixel runs the nine-step shared multiply-accumulate and the
// bit-per-cycle restoring divider, one per channel, taking no new pixel
// meanwhile. A finished result waits in the output register while the
// next pixel is taken in. Configuration must be written through
// cfg_write_en, cfg_index and cfg_data only while the unit is idle; the
// unit does not enforce this. The line stores are not cleared after reset;
// the first two rows of a frame fill them before any result reads them.
module bgra_convolution_3x3_unit #(
  parameter int MAX_WIDTH = bc3_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS = bc3_pkg::COEF_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bc3_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bc3_pkg::out_word_t out_data,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  localparam int CNT_W = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [11:0] width_r;
  logic [15:0] height_r;
  logic [47:0] kleft_r, kcenter_r, kright_r;
  logic [15:0] divisor_r;

  bc3_pkg::cmd_t    cmd;
  logic [CNT_W-1:0] pos_col;
  logic [15:0]      pos_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= bc3_pkg::WIDTH_RESET;
      height_r  <= bc3_pkg::HEIGHT_RESET;
      kleft_r   <= bc3_pkg::KLEFT_RESET;
      kcenter_r <= bc3_pkg::KCENTER_RESET;
      kright_r  <= bc3_pkg::KRIGHT_RESET;
      divisor_r <= bc3_pkg::DIVISOR_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        bc3_pkg::CFG_WIDTH_PIXELS:  width_r   <= cfg_data[11:0];
        bc3_pkg::CFG_HEIGHT_ROWS:   height_r  <= cfg_data[15:0];
        bc3_pkg::CFG_KERNEL_LEFT:   kleft_r   <= cfg_data;
        bc3_pkg::CFG_KERNEL_CENTER: kcenter_r <= cfg_data;
        bc3_pkg::CFG_KERNEL_RIGHT:  kright_r  <= cfg_data;
        bc3_pkg::CFG_DIVISOR:       divisor_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The controller tracks the frame position and sequences the datapath.
  bc3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .COEF_BITS (COEF_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .width_pixels (width_r),
    .height_rows  (height_r),
    .cmd          (cmd),
    .pos_col      (pos_col),
    .pos_row      (pos_row)
  );

  // The datapath holds the line stores, window, accumulators and dividers.
  bc3_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .COEF_BITS (COEF_BITS)
  ) u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .in_px         (in_data),
    .pos_col       (pos_col),
    .pos_row       (pos_row),
    .kernel_left   (kleft_r),
    .kernel_center (kcenter_r),
    .kernel_right  (kright_r),
    .divisor       (divisor_r),
    .out_word      (out_data)
  );

endmodule

@@ test/bgra_convolution_3x3_unit_test.sv @@
module bgra_convolution_3x3_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  bc3_pkg::in_word_t   in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bc3_pkg::out_word_t  out_data;
  logic                cfg_write_en = 1'b0;
  logic [2:0]          cfg_index = bc3_pkg::CFG_WIDTH_PIXELS;
  logic [47:0]         cfg_data = '0;

  bgra_convolution_3x3_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers, kept in step with every write.
  logic [11:0] width_reg = bc3_pkg::WIDTH_RESET;
  logic [15:0] height_reg = bc3_pkg::HEIGHT_RESET;
  logic [47:0] kernel_reg [3] = '{bc3_pkg::KLEFT_RESET, bc3_pkg::KCENTER_RESET,
                                  bc3_pkg::KRIGHT_RESET};
  logic [15:0] divisor_reg = bc3_pkg::DIVISOR_RESET;

  // Shadow copy of the pixel history. The line stores never feed a result
  // before they are written, because geometry only widens at a frame start.
  logic [23:0] upper_line [bc3_pkg::MAX_WIDTH_DEF];
  logic [23:0] lower_line [bc3_pkg::MAX_WIDTH_DEF];
  logic [23:0] neighborhood [3][3] = '{default: '0};
  int          next_col = 0;
  int          next_row = 0;

  bc3_pkg::out_word_t filtered_q [$];
  int          errors = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          random_words = 0;

  // Works out the filtered pixel (if any) caused by one accepted word. The
  // word's bytes are packed red, green, blue from the top.
  function automatic void predict_filtered(logic [23:0] px);
    int w, h, col, row;
    logic [23:0] top, mid;
    longint dv, acc, quo;
    bc3_pkg::out_word_t e;
    logic [7:0] chan [3];
    w = width_reg;
    if (w < 3) w = 3;
    if (w > bc3_pkg::MAX_WIDTH_DEF) w = bc3_pkg::MAX_WIDTH_DEF;
    h = height_reg;
    if (h < 3) h = 3;
    // A narrower width or a lower height written mid-frame takes effect here.
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= h) next_row = 0;
    col = next_col;
    row = next_row;
    top = upper_line[col];
    mid = lower_line[col];
    upper_line[col] = mid;
    lower_line[col] = px;
    for (int r = 0; r < 3; r++) begin
      neighborhood[r][0] = neighborhood[r][1];
      neighborhood[r][1] = neighborhood[r][2];
    end
    neighborhood[0][2] = top;
    neighborhood[1][2] = mid;
    neighborhood[2][2] = px;
    if (row >= 2 && col >= 2) begin
      dv = longint'($signed(divisor_reg));
      if (dv == 0) dv = 1;
      for (int ch = 0; ch < 3; ch++) begin
        acc = 0;
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            acc += longint'(neighborhood[r][c][8*ch +: 8]) *
                   longint'($signed(kernel_reg[c][16*r +: 16]));
        // Negative sums clamp to zero; the quotient truncates toward zero and
        // only its low byte survives, so a negative divisor wraps.
        if (acc < 0) acc = 0;
        quo = acc / dv;
        chan[ch] = quo[7:0];
      end
      e.out_blue = chan[0];
      e.out_green = chan[1];
      e.out_red = chan[2];
      e.out_row = 16'(row - 1);
      e.out_column = 11'(col - 1);
      filtered_q.push_back(e);
    end
    next_col = col + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = row + 1;
      if (next_row >= h) next_row = 0;
    end
  endfunction

  // Receiver side: random stalls, and every accepted word is checked against
  // the oldest expected filtered pixel.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected word %p", $realtime, out_data);
        errors++;
      end else begin
        if (out_data.out_blue !== filtered_q[0].out_blue ||
            out_data.out_green !== filtered_q[0].out_green ||
            out_data.out_red !== filtered_q[0].out_red ||
            out_data.out_row !== filtered_q[0].out_row ||
            out_data.out_column !== filtered_q[0].out_column) begin
          $display("%0t: expected %p got %p", $realtime, filtered_q[0], out_data);
          errors++;
        end
        void'(filtered_q.pop_front());
      end
    end
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Sends one pixel word. Valid is only lowered when a gap is inserted, so it
  // never gets two assignments in the same time step.
  task automatic send_pixel(logic [23:0] px);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{blue: px[7:0], green: px[15:8], red: px[23:16]};
    do @(posedge clk); while (!in_ready);
    predict_filtered(px);
  endtask

  // Waits until every expected pixel has come out, then lets a border pixel
  // still inside the unit settle before any register is touched.
  task automatic drain;
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] value);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      bc3_pkg::CFG_WIDTH_PIXELS:  width_reg = value[11:0];
      bc3_pkg::CFG_HEIGHT_ROWS:   height_reg = value[15:0];
      bc3_pkg::CFG_KERNEL_LEFT:   kernel_reg[0] = value;
      bc3_pkg::CFG_KERNEL_CENTER: kernel_reg[1] = value;
      bc3_pkg::CFG_KERNEL_RIGHT:  kernel_reg[2] = value;
      bc3_pkg::CFG_DIVISOR:       divisor_reg = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_kernel(logic [47:0] left, logic [47:0] center, logic [47:0] right,
                            logic [15:0] div);
    write_reg(bc3_pkg::CFG_KERNEL_LEFT, left);
    write_reg(bc3_pkg::CFG_KERNEL_CENTER, center);
    write_reg(bc3_pkg::CFG_KERNEL_RIGHT, right);
    write_reg(bc3_pkg::CFG_DIVISOR, {32'd0, div});
  endtask

  // Feeds pixels until the position is back at the top left corner. A fixed
  // pixel value is used when solid is set, random content otherwise.
  task automatic send_frame(bit solid = 1'b0, logic [23:0] px = '0);
    do begin
      send_pixel(solid ? px : 24'($urandom));
      if (!solid) random_words++;
    end while (next_col != 0 || next_row != 0);
  endtask

  // The reset kernel passes the bottom center pixel through unchanged.
  task automatic test_reset_identity;
    write_reg(bc3_pkg::CFG_WIDTH_PIXELS, 48'd5);
    write_reg(bc3_pkg::CFG_HEIGHT_ROWS, 48'd4);
    send_frame();
    drain();
  endtask

  // Largest positive weights overflow the byte, largest negative ones clamp
  // to zero, and the divisor runs through its sign and zero cases.
  task automatic test_extreme_weights;
    write_reg(bc3_pkg::CFG_WIDTH_PIXELS, 48'd3);
    write_reg(bc3_pkg::CFG_HEIGHT_ROWS, 48'd3);
    set_kernel(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 16'd1);
    send_frame(1'b1, 24'hFFFFFF);
    send_frame(1'b1, 24'h000000);
    drain();
    set_kernel(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 16'h8000);
    send_frame(1'b1, 24'hFFFFFF);
    drain();
    set_kernel(48'h0001_0002_0003, 48'h0004_0005_0006, 48'h0007_0008_0009, 16'h0000);
    send_frame();
    drain();
    write_reg(bc3_pkg::CFG_DIVISOR, 48'h0000_0000_FFFF);
    send_frame(1'b1, 24'hFFFFFF);
    drain();
    write_reg(bc3_pkg::CFG_DIVISOR, 48'h0000_0000_8000);
    send_frame(1'b1, 24'hFFFFFF);
    drain();
    write_reg(bc3_pkg::CFG_DIVISOR, 48'h0000_0000_7FFF);
    send_frame(1'b1, 24'hFFFFFF);
    drain();
  endtask

  // Widths below three act as three. A width above the line store acts as
  // its full size: one full row plus one pixel lands on the next row, and
  // narrowing to three there shows the position through the results.
  task automatic test_width_saturation;
    set_kernel(48'h0001_0001_0001, 48'h0001_FFF8_0001, 48'h0001_0001_0001, 16'd3);
    write_reg(bc3_pkg::CFG_HEIGHT_ROWS, 48'd3);
    write_reg(bc3_pkg::CFG_WIDTH_PIXELS, 48'd0);
    send_frame();
    drain();
    write_reg(bc3_pkg::CFG_WIDTH_PIXELS, 48'd2);
    send_frame();
    drain();
    write_reg(bc3_pkg::CFG_WIDTH_PIXELS, 48'hFFF);
    repeat (bc3_pkg::MAX_WIDTH_DEF + 1) send_pixel(24'($urandom));
    drain();
    write_reg(bc3_pkg::CFG_WIDTH_PIXELS, 48'd3);
    send_frame();
    drain();
  endtask

  // A height below three acts as three. A huge height is cut short at a row
  // start by a lower one, which sends the next pixel to a new frame.
  task automatic test_height_limits;
    write_reg(bc3_pkg::CFG_WIDTH_PIXELS, 48'd4);
    write_reg(bc3_pkg::CFG_HEIGHT_ROWS, 48'd0);
    send_frame();
    drain();
    write_reg(bc3_pkg::CFG_HEIGHT_ROWS, 48'hFFFF);
    repeat (20) send_pixel(24'($urandom));
    drain();
    write_reg(bc3_pkg::CFG_HEIGHT_ROWS, 48'd3);
    send_frame();
    drain();
  endtask

  // Narrowing the row mid-frame while the position is past the new width
  // pushes the next pixel onto the following row.
  task automatic test_narrow_mid_frame;
    write_reg(bc3_pkg::CFG_WIDTH_PIXELS, 48'd8);
    write_reg(bc3_pkg::CFG_HEIGHT_ROWS, 48'd4);
    repeat (22) send_pixel(24'($urandom));
    drain();
    write_reg(bc3_pkg::CFG_WIDTH_PIXELS, 48'd5);
    send_frame();
    drain();
  endtask

  function automatic logic [47:0] random_column;
    logic [47:0] v;
    for (int r = 0; r < 3; r++)
      v[16*r +: 16] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12) - 4);
    return v;
  endfunction

  // Whole frames of random content at small random geometries and kernels,
  // under one idling pattern.
  task automatic test_random_frames(int idle_pct, int stall_pct, int quota);
    int target;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    target = random_words + quota;
    while (random_words < target) begin
      write_reg(bc3_pkg::CFG_WIDTH_PIXELS,
                ($urandom_range(9) == 0) ? 48'($urandom_range(2))
                                         : 48'($urandom_range(12, 3)));
      write_reg(bc3_pkg::CFG_HEIGHT_ROWS,
                ($urandom_range(9) == 0) ? 48'd0 : 48'($urandom_range(6, 3)));
      set_kernel(random_column(), random_column(), random_column(),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16)));
      repeat ($urandom_range(2, 1)) send_frame();
      drain();
    end
  endtask

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_identity();
    test_extreme_weights();
    test_width_saturation();
    test_height_limits();
    test_narrow_mid_frame();
    random_words = 0;
    test_random_frames(0, 0, 250);
    test_random_frames(67, 0, 250);
    test_random_frames(0, 67, 250);
    test_random_frames(29, 29, 250);
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/bc3_pkg.sv
rtl/core/bc3_ctrl.sv
rtl/core/bc3_datapath.sv
rtl/core/bgra_convolution_3x3_unit.sv
test/bgra_convolution_3x3_unit_test.sv
